// File: hdl/cv3_pkg.sv
// Shared types, widths, register map and reset values of the 3x3 convolution block.
// No dependencies; every other file but cv3_ram refers to it by scoped names.
package cv3_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 4096;
  localparam int PixW      = 8;
  localparam int ColW      = 8;
  localparam int RowW      = 12;
  localparam int WidthW    = 9;
  localparam int HeightW   = 13;
  localparam int KrowW     = 24;
  localparam int CoefW     = 8;
  localparam int ProdW     = 17;
  localparam int SumW      = 20;
  localparam int PaddrW    = 5;
  localparam int PdataW    = 32;
  localparam int LineW     = 2 * PixW;

  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegKtop   = 3'd2;
  localparam logic [2:0] RegKmid   = 3'd3;
  localparam logic [2:0] RegKbot   = 3'd4;

  localparam logic [WidthW-1:0]  WidthRst  = 9'd256;
  localparam logic [HeightW-1:0] HeightRst = 13'd256;
  localparam logic [KrowW-1:0]   KtopRst   = 24'hFFFFFF;
  localparam logic [KrowW-1:0]   KmidRst   = 24'hFF08FF;
  localparam logic [KrowW-1:0]   KbotRst   = 24'hFFFFFF;

  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic [KrowW-1:0]   k_top;
    logic [KrowW-1:0]   k_mid;
    logic [KrowW-1:0]   k_bot;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } meta_t;

  typedef logic [2:0][2:0][PixW-1:0] win_t;

  function automatic logic signed [CoefW-1:0] coef(input logic [KrowW-1:0] krow,
                                                   input logic [1:0] pos);
    logic signed [CoefW-1:0] c;
    case (pos)
      2'd0:    c = krow[7:0];
      2'd1:    c = krow[15:8];
      default: c = krow[23:16];
    endcase
    return c;
  endfunction

endpackage

// File: hdl/cv3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cv3_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/cv3_cfg.sv
// APB-style configuration registers: frame size and three kernel rows.
// Depends on cv3_pkg.
module cv3_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cv3_pkg::PaddrW-1:0] paddr,
  input  logic [cv3_pkg::PdataW-1:0] pwdata,
  output logic [cv3_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output cv3_pkg::cfg_t              cfg_o
);

  cv3_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[cv3_pkg::PaddrW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        cv3_pkg::RegWidth:  cfg_d.width  = pwdata[cv3_pkg::WidthW-1:0];
        cv3_pkg::RegHeight: cfg_d.height = pwdata[cv3_pkg::HeightW-1:0];
        cv3_pkg::RegKtop:   cfg_d.k_top  = pwdata[cv3_pkg::KrowW-1:0];
        cv3_pkg::RegKmid:   cfg_d.k_mid  = pwdata[cv3_pkg::KrowW-1:0];
        cv3_pkg::RegKbot:   cfg_d.k_bot  = pwdata[cv3_pkg::KrowW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cv3_pkg::RegWidth:  prdata = {{(cv3_pkg::PdataW-cv3_pkg::WidthW){1'b0}}, cfg_q.width};
      cv3_pkg::RegHeight: prdata = {{(cv3_pkg::PdataW-cv3_pkg::HeightW){1'b0}}, cfg_q.height};
      cv3_pkg::RegKtop:   prdata = {{(cv3_pkg::PdataW-cv3_pkg::KrowW){1'b0}}, cfg_q.k_top};
      cv3_pkg::RegKmid:   prdata = {{(cv3_pkg::PdataW-cv3_pkg::KrowW){1'b0}}, cfg_q.k_mid};
      cv3_pkg::RegKbot:   prdata = {{(cv3_pkg::PdataW-cv3_pkg::KrowW){1'b0}}, cfg_q.k_bot};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= cv3_pkg::WidthRst;
      cfg_q.height <= cv3_pkg::HeightRst;
      cfg_q.k_top  <= cv3_pkg::KtopRst;
      cfg_q.k_mid  <= cv3_pkg::KmidRst;
      cfg_q.k_bot  <= cv3_pkg::KbotRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/cv3_mac.sv
// Nine pixel-by-coefficient products, registered, then summed into the output register.
// Depends on cv3_pkg.
module cv3_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  cv3_pkg::win_t                       win_i,
  input  cv3_pkg::cfg_t                       cfg_i,
  input  cv3_pkg::meta_t                      meta_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cv3_pkg::SumW-1:0]     conv_sum_o,
  output cv3_pkg::meta_t                      meta_o
);

  logic signed [cv3_pkg::ProdW-1:0] prod_d [9];
  logic signed [cv3_pkg::ProdW-1:0] prod_q [9];
  logic                             s2_valid_q;
  cv3_pkg::meta_t                   s2_meta_q;
  logic                             out_valid_q;
  logic signed [cv3_pkg::SumW-1:0]  sum_d, sum_q;
  cv3_pkg::meta_t                   out_meta_q;
  logic                             out_free, s2_free, s2_ld, out_ld;
  logic [cv3_pkg::KrowW-1:0]        krow [3];

  assign krow[0] = cfg_i.k_top;
  assign krow[1] = cfg_i.k_mid;
  assign krow[2] = cfg_i.k_bot;

  always_comb begin
    logic signed [cv3_pkg::PixW:0]    px;
    logic signed [cv3_pkg::CoefW-1:0] k;
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        px = $signed({1'b0, win_i[m][n]});
        k  = cv3_pkg::coef(krow[m], 2'(n));
        prod_d[3*m+n] = cv3_pkg::ProdW'(px) * cv3_pkg::ProdW'(k);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 9; i++) begin
      sum_d = sum_d + cv3_pkg::SumW'(prod_q[i]);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign s2_free  = !s2_valid_q || out_free;
  assign s2_ld    = valid_i && s2_free;
  assign out_ld   = s2_valid_q && out_free;
  assign ready_o  = s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= valid_i;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ld) begin
      prod_q    <= prod_d;
      s2_meta_q <= meta_i;
    end
    if (out_ld) begin
      sum_q      <= sum_d;
      out_meta_q <= s2_meta_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign conv_sum_o  = sum_q;
  assign meta_o      = out_meta_q;

endmodule

// File: hdl/conv3x3_stream.sv
// Top level of the streaming 3x3 convolution: counters, line-store RAM, window.
// Depends on cv3_pkg, cv3_ram, cv3_cfg and cv3_mac.
//
//   channel | handshake                  | beat contents
//   --------+----------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o    | pixel_i, frame_start_i
//   out     | out_valid_o / out_ready_i  | conv_sum_o, center_row_o, center_col_o,
//           |                            | frame_last_o
//   cfg     | psel, penable, pwrite      | paddr, pwdata, prdata; pready tied high
//
// One pixel per clock unless the output stalls; a result passes s1, s2 and out.
// The single line-store RAM (older and newer rows side by side) is read at accept
// and written back as s1 advances; a read of the entry just written is forwarded.
// Reset clears counters, window and valid flags; no RAM clearing pass is run.
// A stalled output holds the pipeline stage by stage; empty stages keep filling.
module conv3x3_stream (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [cv3_pkg::PixW-1:0]           pixel_i,
  input  logic                               frame_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cv3_pkg::SumW-1:0]    conv_sum_o,
  output logic [cv3_pkg::RowW-1:0]           center_row_o,
  output logic [cv3_pkg::ColW-1:0]           center_col_o,
  output logic                               frame_last_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cv3_pkg::PaddrW-1:0]         paddr,
  input  logic [cv3_pkg::PdataW-1:0]         pwdata,
  output logic [cv3_pkg::PdataW-1:0]         prdata,
  output logic                               pready
);

  cv3_pkg::cfg_t  cfg;
  cv3_pkg::meta_t mac_meta, out_meta;
  cv3_pkg::win_t  win_q, win_d;

  logic [cv3_pkg::ColW-1:0]    col_q, col_d, c;
  logic [cv3_pkg::RowW-1:0]    row_q, row_d, r;
  logic [cv3_pkg::WidthW-1:0]  w;
  logic [cv3_pkg::HeightW-1:0] h;
  logic                        last_col, last_row, emit, in_acc;

  logic                        s1_valid_q, s1_emit_q, s1_last_q, s1_fwd_q;
  logic [cv3_pkg::PixW-1:0]    s1_px_q;
  logic [cv3_pkg::ColW-1:0]    s1_col_q;
  logic [cv3_pkg::RowW-1:0]    s1_row_q;
  logic [cv3_pkg::LineW-1:0]   s1_fwd_data_q, rd_data, wr_data;
  logic [cv3_pkg::PixW-1:0]    top, mid;
  logic                        s1_adv, mac_ready, mac_valid, fwd_hit;

  cv3_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    if (cfg.width < cv3_pkg::WidthW'(3)) begin
      w = cv3_pkg::WidthW'(3);
    end else if (cfg.width > cv3_pkg::WidthW'(cv3_pkg::MaxWidth)) begin
      w = cv3_pkg::WidthW'(cv3_pkg::MaxWidth);
    end else begin
      w = cfg.width;
    end
    if (cfg.height < cv3_pkg::HeightW'(3)) begin
      h = cv3_pkg::HeightW'(3);
    end else if (cfg.height > cv3_pkg::HeightW'(cv3_pkg::MaxHeight)) begin
      h = cv3_pkg::HeightW'(cv3_pkg::MaxHeight);
    end else begin
      h = cfg.height;
    end
  end

  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign c        = frame_start_i ? '0 : col_q;
  assign r        = frame_start_i ? '0 : row_q;
  assign last_col = {1'b0, c} >= (w - cv3_pkg::WidthW'(1));
  assign last_row = {1'b0, r} >= (h - cv3_pkg::HeightW'(1));
  assign emit     = (r >= cv3_pkg::RowW'(2)) && (c >= cv3_pkg::ColW'(2));

  always_comb begin
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : r + cv3_pkg::RowW'(1);
    end else begin
      col_d = c + cv3_pkg::ColW'(1);
      row_d = r;
    end
  end

  // line store: [15:8] older row, [7:0] newer row
  cv3_ram #(
    .Width (cv3_pkg::LineW),
    .Depth (cv3_pkg::MaxWidth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (in_acc),
    .raddr_i (c),
    .rdata_o (rd_data)
  );

  assign top     = s1_fwd_q ? s1_fwd_data_q[cv3_pkg::LineW-1:cv3_pkg::PixW]
                            : rd_data[cv3_pkg::LineW-1:cv3_pkg::PixW];
  assign mid     = s1_fwd_q ? s1_fwd_data_q[cv3_pkg::PixW-1:0] : rd_data[cv3_pkg::PixW-1:0];
  assign wr_data = {mid, s1_px_q};
  assign fwd_hit = s1_valid_q && s1_adv && (s1_col_q == c);

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      win_d[m][0] = win_q[m][1];
      win_d[m][1] = win_q[m][2];
    end
    win_d[0][2] = top;
    win_d[1][2] = mid;
    win_d[2][2] = s1_px_q;
  end

  assign mac_valid     = s1_valid_q && s1_emit_q;
  assign s1_adv        = s1_valid_q && (!s1_emit_q || mac_ready);
  assign mac_meta.row  = s1_row_q - cv3_pkg::RowW'(1);
  assign mac_meta.col  = s1_col_q - cv3_pkg::ColW'(1);
  assign mac_meta.last = s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q       <= pixel_i;
      s1_col_q      <= c;
      s1_row_q      <= r;
      s1_emit_q     <= emit;
      s1_last_q     <= last_col && last_row;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_data_q <= wr_data;
    end
  end

  cv3_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mac_valid),
    .ready_o     (mac_ready),
    .win_i       (win_d),
    .cfg_i       (cfg),
    .meta_i      (mac_meta),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .conv_sum_o  (conv_sum_o),
    .meta_o      (out_meta)
  );

  assign center_row_o = out_meta.row;
  assign center_col_o = out_meta.col;
  assign frame_last_o = out_meta.last;

  a_frame_start_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && frame_start_i |=> s1_valid_q && s1_col_q == '0 && s1_row_q == '0)
    else $error("frame start did not restart the counters");

  a_emit_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q |-> s1_row_q >= cv3_pkg::RowW'(2) && s1_col_q >= cv3_pkg::ColW'(2))
    else $error("result flagged at a border position");

  a_fwd_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && fwd_hit |=> s1_fwd_q && s1_fwd_data_q == $past(wr_data))
    else $error("line store write-back not forwarded");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with an empty first stage");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_stream: random pixel frames, APB setup, 3x3 sum check.
// Depends on cv3_pkg and the conv3x3_stream RTL; the predictor is local to this file.
module testbench;

  typedef struct packed {
    logic [cv3_pkg::PixW-1:0] pixel;
    logic                     sof;
  } pix_beat_t;

  typedef struct packed {
    logic signed [cv3_pkg::SumW-1:0] sum;
    logic [cv3_pkg::RowW-1:0]        row;
    logic [cv3_pkg::ColW-1:0]        col;
    logic                            last;
  } conv_res_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic [cv3_pkg::PixW-1:0]         pixel_i = '0;
  logic                             frame_start_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [cv3_pkg::SumW-1:0]  conv_sum_o;
  logic [cv3_pkg::RowW-1:0]         center_row_o;
  logic [cv3_pkg::ColW-1:0]         center_col_o;
  logic                             frame_last_o;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [cv3_pkg::PaddrW-1:0]       paddr = '0;
  logic [cv3_pkg::PdataW-1:0]       pwdata = '0;
  logic [cv3_pkg::PdataW-1:0]       prdata;
  logic                             pready;

  conv3x3_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .conv_sum_o    (conv_sum_o),
    .center_row_o  (center_row_o),
    .center_col_o  (center_col_o),
    .frame_last_o  (frame_last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow configuration
  logic [cv3_pkg::WidthW-1:0]  cfg_width  = cv3_pkg::WidthRst;
  logic [cv3_pkg::HeightW-1:0] cfg_height = cv3_pkg::HeightRst;
  logic [cv3_pkg::KrowW-1:0]   cfg_ktop   = cv3_pkg::KtopRst;
  logic [cv3_pkg::KrowW-1:0]   cfg_kmid   = cv3_pkg::KmidRst;
  logic [cv3_pkg::KrowW-1:0]   cfg_kbot   = cv3_pkg::KbotRst;

  // shadow datapath state
  logic [cv3_pkg::PixW-1:0] line_old [cv3_pkg::MaxWidth];
  logic [cv3_pkg::PixW-1:0] line_new [cv3_pkg::MaxWidth];
  cv3_pkg::win_t            win      = '0;
  logic [cv3_pkg::ColW-1:0] col_pos  = '0;
  logic [cv3_pkg::RowW-1:0] row_pos  = '0;

  pix_beat_t   pixel_q [$];
  conv_res_t   sum_due_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned beats_seen   = 0;
  int unsigned tx_wait      = 0;
  int unsigned rx_wait      = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  logic        tx_burst     = 1'b0;
  logic        rx_burst     = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void predict_conv(input logic [cv3_pkg::PixW-1:0] px, input logic sof);
    int unsigned                      weff;
    int unsigned                      heff;
    int unsigned                      c;
    int unsigned                      r;
    logic [cv3_pkg::PixW-1:0]         top;
    logic [cv3_pkg::PixW-1:0]         mid;
    logic [cv3_pkg::KrowW-1:0]        krow;
    logic signed [cv3_pkg::CoefW-1:0] k;
    int                               acc;
    logic                             last_c;
    logic                             last_r;
    conv_res_t                        res;
    weff = (cfg_width < 3) ? 3 :
           ((cfg_width > cv3_pkg::MaxWidth) ? cv3_pkg::MaxWidth : cfg_width);
    heff = (cfg_height < 3) ? 3 :
           ((cfg_height > cv3_pkg::MaxHeight) ? cv3_pkg::MaxHeight : cfg_height);
    if (sof) begin
      col_pos = '0;
      row_pos = '0;
    end
    c = col_pos;
    r = row_pos;
    top = line_old[c];
    mid = line_new[c];
    line_old[c] = mid;
    line_new[c] = px;
    for (int m = 0; m < 3; m++) begin
      win[m][0] = win[m][1];
      win[m][1] = win[m][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    last_c = (c >= weff - 1);
    last_r = (r >= heff - 1);
    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (int m = 0; m < 3; m++) begin
        krow = (m == 0) ? cfg_ktop : ((m == 1) ? cfg_kmid : cfg_kbot);
        for (int n = 0; n < 3; n++) begin
          k = krow[cv3_pkg::CoefW*n +: cv3_pkg::CoefW];
          acc += int'(win[m][n]) * int'(k);
        end
      end
      res.sum  = acc[cv3_pkg::SumW-1:0];
      res.row  = cv3_pkg::RowW'(r - 1);
      res.col  = cv3_pkg::ColW'(c - 1);
      res.last = last_c && last_r;
      sum_due_q.push_back(res);
    end
    if (last_c) begin
      col_pos = '0;
      row_pos = last_r ? '0 : cv3_pkg::RowW'(r + 1);
    end else begin
      col_pos = cv3_pkg::ColW'(c + 1);
    end
  endfunction

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin : pixel_drv
    pix_beat_t b;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      pixel_i       <= '0;
      frame_start_i <= 1'b0;
      tx_wait       <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_conv(pixel_i, frame_start_i);
      if (in_valid_i && !in_ready_o) begin
        // hold
      end else if (tx_wait != 0) begin
        in_valid_i <= 1'b0;
        tx_wait    <= tx_wait - 1;
      end else if (pixel_q.size() != 0) begin
        b = pixel_q.pop_front();
        in_valid_i    <= 1'b1;
        pixel_i       <= b.pixel;
        frame_start_i <= b.sof;
        tx_wait       <= tx_burst ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : sum_mon
    conv_res_t   want;
    int unsigned rx_next;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
    end else begin
      rx_next = rx_wait;
      if (out_valid_o && out_ready_i) begin
        if (sum_due_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected beat at %0t: sum %0d row %0d col %0d last %0b", $time,
                     conv_sum_o, center_row_o, center_col_o, frame_last_o);
          mismatch_cnt++;
        end else begin
          want = sum_due_q.pop_front();
          if (conv_sum_o !== want.sum || center_row_o !== want.row ||
              center_col_o !== want.col || frame_last_o !== want.last) begin
            if (mismatch_cnt < 10)
              $display(
                "mismatch %0t exp/act: sum %0d/%0d row %0d/%0d col %0d/%0d last %0b/%0b",
                $time, want.sum, conv_sum_o, want.row, center_row_o, want.col,
                center_col_o, want.last, frame_last_o);
            mismatch_cnt++;
          end
        end
        beats_seen <= beats_seen + 1;
        rx_next = rx_burst ? 0 : $urandom_range(0, 12);
      end else if (rx_wait != 0) begin
        rx_next = rx_wait - 1;
      end
      rx_wait     <= rx_next;
      out_ready_i <= (rx_next == 0) && (hold_left == 0);
    end
  end

  // long output stall so the pipeline backs up into the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_seen >= 4) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [cv3_pkg::PdataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cv3_pkg::RegWidth:  cfg_width  = val[cv3_pkg::WidthW-1:0];
      cv3_pkg::RegHeight: cfg_height = val[cv3_pkg::HeightW-1:0];
      cv3_pkg::RegKtop:   cfg_ktop   = val[cv3_pkg::KrowW-1:0];
      cv3_pkg::RegKmid:   cfg_kmid   = val[cv3_pkg::KrowW-1:0];
      cv3_pkg::RegKbot:   cfg_kbot   = val[cv3_pkg::KrowW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || sum_due_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_pixel(input logic [cv3_pkg::PixW-1:0] px, input logic sof);
    pix_beat_t b;
    b.pixel = px;
    b.sof   = sof;
    pixel_q.push_back(b);
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stim
    int unsigned               wval;
    int unsigned               hval;
    int unsigned               weff;
    int unsigned               heff;
    int unsigned               prev_weff;
    int unsigned               rows;
    int unsigned               n;
    int unsigned               pick;
    int unsigned               sent;
    logic [cv3_pkg::KrowW-1:0] krow [3];
    logic                      sof;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset kernel, smallest frame, alternating black and white
    reg_write(cv3_pkg::RegWidth, 32'd3);
    reg_write(cv3_pkg::RegHeight, 32'd3);
    for (int i = 0; i < 9; i++) push_pixel(i[0] ? 8'hFF : 8'h00, i == 0);

    // most negative sum
    wait_idle();
    reg_write(cv3_pkg::RegKtop, 32'hA580_8080);
    reg_write(cv3_pkg::RegKmid, 32'h5A80_8080);
    reg_write(cv3_pkg::RegKbot, 32'hFF80_8080);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);

    // most positive sum
    wait_idle();
    reg_write(cv3_pkg::RegKtop, 32'h007F_7F7F);
    reg_write(cv3_pkg::RegKmid, 32'h007F_7F7F);
    reg_write(cv3_pkg::RegKbot, 32'h007F_7F7F);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);

    // two full rows and the start of a third, width above range clamps to the maximum
    wait_idle();
    tx_burst = ($urandom_range(0, 1) == 0);
    rx_burst = 1'b0;
    reg_write(cv3_pkg::RegWidth, 32'h0000_01FF);
    reg_write(cv3_pkg::RegHeight, 32'd3);
    reg_write(cv3_pkg::RegKtop, $urandom);
    reg_write(cv3_pkg::RegKmid, $urandom);
    reg_write(cv3_pkg::RegKbot, $urandom);
    for (int i = 0; i < 2 * cv3_pkg::MaxWidth + 24; i++)
      push_pixel(cv3_pkg::PixW'($urandom_range(0, 255)), i == 0);
    prev_weff = cv3_pkg::MaxWidth;

    sent = 0;
    while (sent < 100) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      wval = (pick == 0) ? $urandom_range(0, 2) :
             ((pick == 1) ? $urandom_range(13, 40) : $urandom_range(3, 12));
      pick = $urandom_range(0, 9);
      if (pick == 0) hval = $urandom_range(0, 2);
      else if (pick == 1) hval = ($urandom_range(0, 1) != 0) ? 4096 : $urandom_range(4097, 8191);
      else hval = $urandom_range(3, 8);
      weff = (wval < 3) ? 3 : wval;
      heff = (hval < 3) ? 3 : ((hval > cv3_pkg::MaxHeight) ? cv3_pkg::MaxHeight : hval);
      for (int k = 0; k < 3; k++) begin
        pick = $urandom_range(0, 5);
        krow[k] = (pick == 0) ? 24'h808080 :
                  ((pick == 1) ? 24'h7F7F7F : cv3_pkg::KrowW'($urandom));
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      reg_write(cv3_pkg::RegWidth, ($urandom & 32'hFFFF_FE00) | wval);
      reg_write(cv3_pkg::RegHeight, ($urandom & 32'hFFFF_E000) | hval);
      reg_write(cv3_pkg::RegKtop, ($urandom & 32'hFF00_0000) | 32'(krow[0]));
      reg_write(cv3_pkg::RegKmid, ($urandom & 32'hFF00_0000) | 32'(krow[1]));
      reg_write(cv3_pkg::RegKbot, ($urandom & 32'hFF00_0000) | 32'(krow[2]));
      rows = (heff <= 8) ? heff * $urandom_range(1, 3) : $urandom_range(3, 12);
      n = weff * rows + $urandom_range(0, 2 * weff);
      if (n > 100 - sent) n = 100 - sent;
      // a wider row needs fresh line stores, so restart the frame
      sof = (weff > prev_weff) || ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n; i++)
        push_pixel(cv3_pkg::PixW'($urandom_range(0, 255)),
                   (i == 0) ? sof : ($urandom_range(0, 49) == 0));
      prev_weff = weff;
      sent += n;
    end

    wait_idle();
    if (mismatch_cnt == 0 && sum_due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
